/* rtl/aps_pkg.sv */
// Shared types, codes and helpers for the animation progress sequencer.
package aps_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int DIV_CNT_W     = $clog2(FRACTION_BITS + 1);
    localparam int PROG_W        = 17;

    localparam logic [FRACTION_BITS:0] ONE_VALUE = {1'b1, {FRACTION_BITS{1'b0}}};

    // Command opcodes.
    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_START    = 3'd1;
    localparam logic [2:0] OP_COMPLETE = 3'd2;
    localparam logic [2:0] OP_STOP     = 3'd3;
    localparam logic [2:0] OP_PAUSE    = 3'd4;
    localparam logic [2:0] OP_RESUME   = 3'd5;

    // Result event kinds.
    localparam logic [2:0] EV_UPDATE   = 3'd0;
    localparam logic [2:0] EV_STARTED  = 3'd1;
    localparam logic [2:0] EV_REPEATED = 3'd2;
    localparam logic [2:0] EV_ENDED    = 3'd3;
    localparam logic [2:0] EV_STATUS   = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_DURATION    = 3'd0;
    localparam logic [2:0] CFG_START_DELAY = 3'd1;
    localparam logic [2:0] CFG_EXTRA       = 3'd2;
    localparam logic [2:0] CFG_REVERSE     = 3'd3;
    localparam logic [2:0] CFG_FILL        = 3'd4;

    localparam logic [1:0] FILL_ZERO = 2'd1;
    localparam logic [1:0] FILL_ONE  = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] now_ms;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0]        event_kind;
        logic [PROG_W-1:0] progress;
        logic              running;
        logic              paused;
        logic              last;
    } res_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_ROUTE,
        ST_DIV,
        ST_STARTED,
        ST_UPDATE,
        ST_FILL,
        ST_FINAL,
        ST_STATUS
    } aps_state_t;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_STARTED,
        EM_UPDATE,
        EM_FILL,
        EM_FINAL,
        EM_STATUS
    } emit_sel_t;

    typedef enum logic [1:0] {
        FIN_NONE,
        FIN_REPEATED,
        FIN_ENDED
    } final_t;

    typedef struct packed {
        logic      load;
        logic      eval;
        logic      div_step;
        emit_sel_t emit_sel;
        logic      last;
    } aps_cmd_t;

    typedef struct packed {
        logic   need_update;
        logic   need_div;
        logic   need_started;
        logic   need_fill;
        final_t final_kind;
        logic   div_done;
        logic   out_free;
    } aps_stat_t;

    // Fits a fraction into the progress field, masking off any bits above it.
    function automatic logic [PROG_W-1:0] to_progress(input logic [FRACTION_BITS:0] v);
        logic [FRACTION_BITS+PROG_W:0] ext;
        ext = {{PROG_W{1'b0}}, v};
        return ext[PROG_W-1:0];
    endfunction

endpackage

/* rtl/aps_ctrl.sv */
// Controller: sequences evaluation, division and result emission for one item.
module aps_ctrl
    import aps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  aps_stat_t st,
    output aps_cmd_t  ctl
);

    aps_state_t state_reg;
    aps_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_ROUTE;
            end
            // The emission plan is registered at the end of the evaluation cycle,
            // so the route is chosen in the cycle after it.
            ST_ROUTE:
            begin
                priority if (!st.need_update)
                begin
                    state_next = ST_STATUS;
                end
                else if (st.need_div)
                begin
                    state_next = ST_DIV;
                end
                else if (st.need_started)
                begin
                    state_next = ST_STARTED;
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_DIV:
            begin
                if (st.div_done)
                begin
                    state_next = st.need_started ? ST_STARTED : ST_UPDATE;
                end
            end
            ST_STARTED:
            begin
                if (st.out_free)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (st.out_free)
                begin
                    priority if (st.need_fill)
                    begin
                        state_next = ST_FILL;
                    end
                    else if (st.final_kind != FIN_NONE)
                    begin
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FILL:
            begin
                if (st.out_free)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL, ST_STATUS:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_ready    = 1'b0;
        ctl.load     = 1'b0;
        ctl.eval     = 1'b0;
        ctl.div_step = 1'b0;
        ctl.emit_sel = EM_NONE;
        ctl.last     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                ctl.load  = cmd_valid;
            end
            ST_EVAL:
            begin
                ctl.eval = 1'b1;
            end
            ST_ROUTE:
            begin
                cmd_ready = 1'b0;
            end
            ST_DIV:
            begin
                ctl.div_step = !st.div_done;
            end
            ST_STARTED:
            begin
                if (st.out_free)
                begin
                    ctl.emit_sel = EM_STARTED;
                end
            end
            ST_UPDATE:
            begin
                if (st.out_free)
                begin
                    ctl.emit_sel = EM_UPDATE;
                    ctl.last     = !st.need_fill && (st.final_kind == FIN_NONE);
                end
            end
            ST_FILL:
            begin
                if (st.out_free)
                begin
                    ctl.emit_sel = EM_FILL;
                end
            end
            ST_FINAL:
            begin
                if (st.out_free)
                begin
                    ctl.emit_sel = EM_FINAL;
                    ctl.last     = 1'b1;
                end
            end
            ST_STATUS:
            begin
                if (st.out_free)
                begin
                    ctl.emit_sel = EM_STATUS;
                    ctl.last     = 1'b1;
                end
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/aps_dpath.sv */
// Datapath: configuration, sequencer state, serial divider and result register.
module aps_dpath
    import aps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_item_t   cmd,
    input  aps_cmd_t    ctl,
    output aps_stat_t   st,
    output logic        res_valid,
    input  logic        res_ready,
    output res_item_t   res,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Configuration.
    logic [15:0] duration_reg;
    logic [15:0] delay_reg;
    logic [7:0]  extra_reg;
    logic        rev_mode_reg;
    logic [1:0]  fill_reg;

    // Latched command.
    logic [2:0]  op_reg;
    logic [31:0] now_reg;

    // Sequencer state.
    logic        running_reg,    running_next;
    logic        started_reg,    started_next;
    logic        rev_reg,        rev_next;
    logic        paused_reg,     paused_next;
    logic        delay_done_reg, delay_done_next;
    logic [7:0]  cycles_reg,     cycles_next;
    logic [31:0] cst_reg,        cst_next;
    logic        sv_reg,         sv_next;
    logic [31:0] pe_reg,         pe_next;

    // Emission plan for the current item.
    logic        plan_update_reg,   plan_update_next;
    logic        plan_started_reg,  plan_started_next;
    logic        plan_div_reg,      plan_div_next;
    logic        plan_rev_reg,      plan_rev_next;
    logic        plan_fill_reg,     plan_fill_next;
    logic        plan_fill_one_reg, plan_fill_one_next;
    final_t      plan_final_reg,    plan_final_next;

    // Divider.
    logic [15:0]              rem_reg, rem_next;
    logic [FRACTION_BITS-1:0] quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]     cnt_reg, cnt_next;

    // Result register.
    logic      res_valid_reg, res_valid_next;
    res_item_t res_reg,       res_next;

    logic [31:0]        delay_base;
    logic [31:0]        delay_elapsed;
    logic [31:0]        base;
    logic [31:0]        elapsed;
    logic               cycle_end;
    logic [16:0]        rem_sh;
    logic [FRACTION_BITS:0] upd_frac;
    logic [FRACTION_BITS:0] upd_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duration_reg <= '0;
            delay_reg    <= '0;
            extra_reg    <= '0;
            rev_mode_reg <= 1'b0;
            fill_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DURATION:    duration_reg <= cfg_data;
                CFG_START_DELAY: delay_reg    <= cfg_data;
                CFG_EXTRA:       extra_reg    <= cfg_data[7:0];
                CFG_REVERSE:     rev_mode_reg <= cfg_data[0];
                CFG_FILL:        fill_reg     <= cfg_data[1:0];
                default:         fill_reg     <= fill_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg  <= cmd.opcode;
            now_reg <= cmd.now_ms;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg       <= 1'b0;
            started_reg       <= 1'b0;
            rev_reg           <= 1'b0;
            paused_reg        <= 1'b0;
            delay_done_reg    <= 1'b1;
            cycles_reg        <= '0;
            cst_reg           <= '1;
            sv_reg            <= 1'b0;
            pe_reg            <= '0;
            plan_update_reg   <= 1'b0;
            plan_started_reg  <= 1'b0;
            plan_div_reg      <= 1'b0;
            plan_rev_reg      <= 1'b0;
            plan_fill_reg     <= 1'b0;
            plan_fill_one_reg <= 1'b0;
            plan_final_reg    <= FIN_NONE;
            cnt_reg           <= '0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            running_reg       <= running_next;
            started_reg       <= started_next;
            rev_reg           <= rev_next;
            paused_reg        <= paused_next;
            delay_done_reg    <= delay_done_next;
            cycles_reg        <= cycles_next;
            cst_reg           <= cst_next;
            sv_reg            <= sv_next;
            pe_reg            <= pe_next;
            plan_update_reg   <= plan_update_next;
            plan_started_reg  <= plan_started_next;
            plan_div_reg      <= plan_div_next;
            plan_rev_reg      <= plan_rev_next;
            plan_fill_reg     <= plan_fill_next;
            plan_fill_one_reg <= plan_fill_one_next;
            plan_final_reg    <= plan_final_next;
            cnt_reg           <= cnt_next;
            res_valid_reg     <= res_valid_next;
        end
    end

    // Elapsed times: the delay is measured from the first tick after start,
    // the cycle from its own start time, or from this tick if that is unset.
    assign delay_base    = sv_reg ? cst_reg : now_reg;
    assign delay_elapsed = now_reg - delay_base;
    assign base          = (sv_reg && delay_done_reg) ? cst_reg : now_reg;
    assign elapsed       = now_reg - base;
    assign cycle_end     = (duration_reg == '0) || (elapsed >= {16'b0, duration_reg});

    always_comb
    begin
        running_next       = running_reg;
        started_next       = started_reg;
        rev_next           = rev_reg;
        paused_next        = paused_reg;
        delay_done_next    = delay_done_reg;
        cycles_next        = cycles_reg;
        cst_next           = cst_reg;
        sv_next            = sv_reg;
        pe_next            = pe_reg;
        plan_update_next   = plan_update_reg;
        plan_started_next  = plan_started_reg;
        plan_div_next      = plan_div_reg;
        plan_rev_next      = plan_rev_reg;
        plan_fill_next     = plan_fill_reg;
        plan_fill_one_next = plan_fill_one_reg;
        plan_final_next    = plan_final_reg;

        if (ctl.eval)
        begin
            plan_update_next   = 1'b0;
            plan_started_next  = 1'b0;
            plan_div_next      = 1'b0;
            plan_rev_next      = rev_reg;
            plan_fill_next     = 1'b0;
            plan_fill_one_next = 1'b0;
            plan_final_next    = FIN_NONE;
            unique case (op_reg)
                OP_TICK:
                begin
                    if (running_reg && !paused_reg)
                    begin
                        if (!delay_done_reg && (delay_elapsed < {16'b0, delay_reg}))
                        begin
                            cst_next = delay_base;
                            sv_next  = 1'b1;
                        end
                        else
                        begin
                            delay_done_next   = 1'b1;
                            started_next      = 1'b1;
                            plan_started_next = !started_reg;
                            cst_next          = base;
                            sv_next           = 1'b1;
                            plan_update_next  = 1'b1;
                            plan_div_next     = !cycle_end;
                            if (cycle_end)
                            begin
                                if (extra_reg == cycles_reg)
                                begin
                                    running_next       = 1'b0;
                                    plan_fill_next     = (fill_reg == FILL_ZERO) ||
                                                         (fill_reg == FILL_ONE);
                                    plan_fill_one_next = (fill_reg == FILL_ONE);
                                    plan_final_next    = FIN_ENDED;
                                end
                                else
                                begin
                                    if (extra_reg != '0)
                                    begin
                                        cycles_next = cycles_reg + 8'd1;
                                    end
                                    if (rev_mode_reg)
                                    begin
                                        rev_next = !rev_reg;
                                    end
                                    sv_next         = 1'b0;
                                    plan_final_next = FIN_REPEATED;
                                end
                            end
                        end
                    end
                end
                OP_START:
                begin
                    cst_next        = '1;
                    sv_next         = 1'b0;
                    running_next    = 1'b1;
                    started_next    = 1'b0;
                    rev_next        = 1'b0;
                    cycles_next     = '0;
                    delay_done_next = (delay_reg == '0);
                end
                OP_COMPLETE:
                begin
                    if (running_reg)
                    begin
                        started_next       = 1'b1;
                        plan_started_next  = !started_reg;
                        plan_update_next   = 1'b1;
                        running_next       = 1'b0;
                        plan_fill_next     = (fill_reg == FILL_ZERO) || (fill_reg == FILL_ONE);
                        plan_fill_one_next = (fill_reg == FILL_ONE);
                        plan_final_next    = FIN_ENDED;
                    end
                end
                OP_STOP:
                begin
                    running_next = 1'b0;
                end
                OP_PAUSE:
                begin
                    if (running_reg && !paused_reg)
                    begin
                        pe_next     = sv_reg ? (now_reg - cst_reg) : '0;
                        paused_next = 1'b1;
                    end
                end
                OP_RESUME:
                begin
                    if (paused_reg)
                    begin
                        cst_next    = now_reg - pe_reg;
                        sv_next     = 1'b1;
                        paused_next = 1'b0;
                    end
                end
                default:
                begin
                    plan_update_next = 1'b0;
                end
            endcase
        end
    end

    // Restoring division of (elapsed << FRACTION_BITS) by the duration; the
    // divider only runs when elapsed is below the duration, so the partial
    // remainder always fits in 16 bits.
    assign rem_sh = {rem_reg, 1'b0};

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (ctl.eval)
        begin
            rem_next = elapsed[15:0];
            quo_next = '0;
            cnt_next = DIV_CNT_W'(FRACTION_BITS);
        end
        else if (ctl.div_step)
        begin
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (rem_sh >= {1'b0, duration_reg})
            begin
                rem_next = 16'(rem_sh - {1'b0, duration_reg});
                quo_next = {quo_reg[FRACTION_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[15:0];
                quo_next = {quo_reg[FRACTION_BITS-2:0], 1'b0};
            end
        end
    end

    assign upd_frac = plan_div_reg ? {1'b0, quo_reg} : ONE_VALUE;
    assign upd_val  = plan_rev_reg ? (ONE_VALUE - upd_frac) : upd_frac;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (ctl.emit_sel != EM_NONE)
        begin
            res_valid_next      = 1'b1;
            res_next.event_kind = EV_STATUS;
            res_next.progress   = '0;
            res_next.running    = running_reg;
            res_next.paused     = paused_reg;
            res_next.last       = ctl.last;
            unique case (ctl.emit_sel)
                EM_STARTED:
                begin
                    res_next.event_kind = EV_STARTED;
                    res_next.running    = 1'b1;
                end
                EM_UPDATE:
                begin
                    res_next.event_kind = EV_UPDATE;
                    res_next.progress   = to_progress(upd_val);
                    res_next.running    = 1'b1;
                end
                EM_FILL:
                begin
                    res_next.event_kind = EV_UPDATE;
                    res_next.progress   = plan_fill_one_reg ? to_progress(ONE_VALUE) : '0;
                end
                EM_FINAL:
                begin
                    res_next.event_kind = (plan_final_reg == FIN_REPEATED) ?
                                          EV_REPEATED : EV_ENDED;
                end
                default:
                begin
                    res_next.event_kind = EV_STATUS;
                end
            endcase
        end
    end

    assign st.need_update  = plan_update_reg;
    assign st.need_div     = plan_div_reg;
    assign st.need_started = plan_started_reg;
    assign st.need_fill    = plan_fill_reg;
    assign st.final_kind   = plan_final_reg;
    assign st.div_done     = (cnt_reg == '0);
    assign st.out_free     = !res_valid_reg || res_ready;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* rtl/animation_progress_sequencer.sv */
// Top level of the animation progress sequencer.
// An item is taken, evaluated and routed before its first result is registered; on a tick inside a
// cycle the bit-serial divider runs in between. Further results follow one per cycle while the
// output is not stalled. A new item is taken only after the last result of the previous one,
// and an item causes up to four results. Reset is asynchronous, active low; ready at once.
module animation_progress_sequencer
    import aps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_item_t   cmd,
    output logic        res_valid,
    input  logic        res_ready,
    output res_item_t   res,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    aps_cmd_t  ctl;
    aps_stat_t st;

    aps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .st        (st),
        .ctl       (ctl)
    );

    aps_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ctl       (ctl),
        .st        (st),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

/* rtl/aps_checker.sv */
// Port-level checks for the animation progress sequencer, bound to the top level.
module aps_checker
    import aps_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        res_valid,
    input logic        res_ready,
    input res_item_t   res
);

    // A waiting result item holds until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result item changed while stalled");

    // An item is worked on alone: no second item right after one is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("item taken while the previous one is in work");

    // Only update items carry a fraction.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.event_kind != EV_UPDATE) |-> (res.progress == '0))
        else $error("non-update item carries progress");

    // Status and ended items close the results of their item.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && ((res.event_kind == EV_STATUS) || (res.event_kind == EV_ENDED))
        |-> res.last)
        else $error("status or ended item not marked last");

    // An ended item reports the animation as stopped.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.event_kind == EV_ENDED) |-> !res.running)
        else $error("ended item reports running");

endmodule

bind animation_progress_sequencer aps_checker u_aps_checker (.*);
